// ===== rtl/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

    localparam int unsigned YEAR_W   = 11;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned MICRO_W  = 20;
    localparam int unsigned EPOCH_W  = 31;
    localparam int unsigned OFFSET_W = 5;
    localparam int unsigned TIME_W   = 32;

    localparam logic [TIME_W-1:0] SECS_PER_MINUTE = 32'd60;
    localparam logic [TIME_W-1:0] SECS_PER_HOUR   = 32'd3600;
    localparam logic [TIME_W-1:0] SECS_PER_DAY    = 32'd86400;
    localparam logic [TIME_W-1:0] COMMON_YEAR_SECS = 32'd31536000;
    localparam logic [TIME_W-1:0] LEAP_YEAR_SECS   = 32'd31622400;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 5'sd8;

    // walk starts at 1970, residues of the start year kept as counters
    localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 11'd1970;
    localparam logic [YEAR_W-1:0] PRE_EPOCH_YEAR = 11'd1969;
    localparam logic [1:0]        EPOCH_MOD4     = 2'd2;
    localparam logic [6:0]        EPOCH_MOD100   = 7'd70;
    localparam logic [8:0]        EPOCH_MOD400   = 9'd370;
    localparam logic [6:0]        LAST_MOD100    = 7'd99;
    localparam logic [8:0]        LAST_MOD400    = 9'd399;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
    localparam logic [DAY_W-1:0]   LAST_DAY_DEC = 5'd31;

    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE
    } esc_phase_t;

    typedef struct packed {
        logic       load;
        logic       settle;
        logic       step;
        esc_phase_t phase;
        logic       out_load;
    } esc_cmd_t;

    typedef struct packed {
        logic neg;
        logic ge;
        logic month_last;
    } esc_status_t;

    // length of a month in seconds
    function automatic logic [TIME_W-1:0] month_secs(input logic leap,
                                                     input logic [MONTH_W-1:0] month);
        logic [TIME_W-1:0] secs;
        begin
            case (month)
                4'd2:                       secs = leap ? 32'd2505600 : 32'd2419200;
                4'd4, 4'd6, 4'd9, 4'd11:    secs = 32'd2592000;
                default:                    secs = 32'd2678400;
            endcase
            return secs;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/esc_datapath.sv =====
`default_nettype none

module esc_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire esc_pkg::esc_cmd_t                 cmd,
    output esc_pkg::esc_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [esc_pkg::OFFSET_W-1:0]      cfg_data,
    input  wire logic [esc_pkg::EPOCH_W-1:0]       epoch_seconds,
    input  wire logic [esc_pkg::MICRO_W-1:0]       micro_part,
    output logic      [esc_pkg::YEAR_W-1:0]        cal_year,
    output logic      [esc_pkg::MONTH_W-1:0]       cal_month,
    output logic      [esc_pkg::DAY_W-1:0]         cal_day,
    output logic      [esc_pkg::HOUR_W-1:0]        cal_hour,
    output logic      [esc_pkg::MINUTE_W-1:0]      cal_minute,
    output logic      [esc_pkg::SECOND_W-1:0]      cal_second,
    output logic      [esc_pkg::MICRO_W-1:0]       cal_micro
);

    logic signed [esc_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [17:0]                  off_secs;
    logic signed [esc_pkg::TIME_W:0]     sum_reg;
    logic [esc_pkg::TIME_W-1:0]          t_reg;
    logic [esc_pkg::TIME_W-1:0]          sub_val;
    logic [esc_pkg::TIME_W-1:0]          diff;
    logic                                leap;
    logic [esc_pkg::YEAR_W-1:0]          year_reg;
    logic [1:0]                          mod4_reg;
    logic [6:0]                          mod100_reg;
    logic [8:0]                          mod400_reg;
    logic [esc_pkg::MONTH_W-1:0]         month_reg;
    logic [esc_pkg::DAY_W-1:0]           day_reg;
    logic [esc_pkg::HOUR_W-1:0]          hour_reg;
    logic [esc_pkg::MINUTE_W-1:0]        minute_reg;
    logic [esc_pkg::MICRO_W-1:0]         micro_reg;

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= esc_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            offset_reg <= cfg_data;
        end
    end

    // offset sign-extended to the product width before the multiply
    assign off_secs = $signed({{(18 - esc_pkg::OFFSET_W){offset_reg[esc_pkg::OFFSET_W-1]}},
                               offset_reg}) * 18'sd3600;

    // gregorian rule from the residue counters
    assign leap = (mod400_reg == 9'd0) || ((mod4_reg == 2'd0) && (mod100_reg != 7'd0));

    always_comb
    begin
        case (cmd.phase)
            esc_pkg::PH_YEAR:   sub_val = leap ? esc_pkg::LEAP_YEAR_SECS
                                               : esc_pkg::COMMON_YEAR_SECS;
            esc_pkg::PH_MONTH:  sub_val = esc_pkg::month_secs(leap, month_reg);
            esc_pkg::PH_DAY:    sub_val = esc_pkg::SECS_PER_DAY;
            esc_pkg::PH_HOUR:   sub_val = esc_pkg::SECS_PER_HOUR;
            esc_pkg::PH_MINUTE: sub_val = esc_pkg::SECS_PER_MINUTE;
            default:            sub_val = esc_pkg::SECS_PER_MINUTE;
        endcase
    end

    assign diff = t_reg - sub_val;

    assign status.neg        = sum_reg[esc_pkg::TIME_W];
    assign status.ge         = (t_reg >= sub_val);
    assign status.month_last = (month_reg == esc_pkg::DECEMBER);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg   <= $signed({2'b00, epoch_seconds}) + {{15{off_secs[17]}}, off_secs};
            micro_reg <= micro_part;
        end

        if (cmd.settle)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            mod4_reg   <= esc_pkg::EPOCH_MOD4;
            mod100_reg <= esc_pkg::EPOCH_MOD100;
            mod400_reg <= esc_pkg::EPOCH_MOD400;
            if (sum_reg[esc_pkg::TIME_W])
            begin
                // before the epoch: stays within the last day of 1969
                t_reg     <= sum_reg[esc_pkg::TIME_W-1:0] + esc_pkg::SECS_PER_DAY;
                year_reg  <= esc_pkg::PRE_EPOCH_YEAR;
                month_reg <= esc_pkg::DECEMBER;
                day_reg   <= esc_pkg::LAST_DAY_DEC;
            end
            else
            begin
                t_reg     <= sum_reg[esc_pkg::TIME_W-1:0];
                year_reg  <= esc_pkg::EPOCH_YEAR;
                month_reg <= esc_pkg::JANUARY;
                day_reg   <= esc_pkg::FIRST_DAY;
            end
        end
        else if (cmd.step)
        begin
            t_reg <= diff;
            case (cmd.phase)
                esc_pkg::PH_YEAR:
                begin
                    year_reg   <= year_reg + 11'd1;
                    mod4_reg   <= mod4_reg + 2'd1;
                    mod100_reg <= (mod100_reg == esc_pkg::LAST_MOD100) ? 7'd0
                                                                        : mod100_reg + 7'd1;
                    mod400_reg <= (mod400_reg == esc_pkg::LAST_MOD400) ? 9'd0
                                                                        : mod400_reg + 9'd1;
                end
                esc_pkg::PH_MONTH:  month_reg  <= month_reg + 4'd1;
                esc_pkg::PH_DAY:    day_reg    <= day_reg + 5'd1;
                esc_pkg::PH_HOUR:   hour_reg   <= hour_reg + 5'd1;
                esc_pkg::PH_MINUTE: minute_reg <= minute_reg + 6'd1;
                default:            minute_reg <= minute_reg;
            endcase
        end

        if (cmd.out_load)
        begin
            cal_year   <= year_reg;
            cal_month  <= month_reg;
            cal_day    <= day_reg;
            cal_hour   <= hour_reg;
            cal_minute <= minute_reg;
            cal_second <= t_reg[esc_pkg::SECOND_W-1:0];
            cal_micro  <= micro_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/esc_ctrl.sv =====
`default_nettype none

module esc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire esc_pkg::esc_status_t  status,
    output esc_pkg::esc_cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_HOUR,
        S_MINUTE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.settle   = 1'b0;
        cmd.step     = 1'b0;
        cmd.phase    = esc_pkg::PH_YEAR;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                cmd.settle = 1'b1;
                state_next = status.neg ? S_HOUR : S_YEAR;
            end
            S_YEAR:
            begin
                cmd.phase = esc_pkg::PH_YEAR;
                cmd.step  = status.ge;
                if (!status.ge)
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                cmd.phase = esc_pkg::PH_MONTH;
                cmd.step  = status.ge && !status.month_last;
                if (!status.ge || status.month_last)
                begin
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                cmd.phase = esc_pkg::PH_DAY;
                cmd.step  = status.ge;
                if (!status.ge)
                begin
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                cmd.phase = esc_pkg::PH_HOUR;
                cmd.step  = status.ge;
                if (!status.ge)
                begin
                    state_next = S_MINUTE;
                end
            end
            S_MINUTE:
            begin
                cmd.phase = esc_pkg::PH_MINUTE;
                cmd.step  = status.ge;
                if (!status.ge)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// converts a unix timestamp (whole seconds since 1970-01-01 00:00:00 utc, plus a
// microsecond part that is passed through untouched) into local calendar year, month,
// day, hour, minute and second; the zone offset in whole hours (signed, reset +8) is
// to be written by the user over the cfg port only while the block is idle, which
// the block itself does not enforce, and is added before conversion; one request is
// worked on at a time: the seconds are walked down by one subtractor, first a year
// per cycle from 1970, then a month per cycle, a day, an hour and a minute per cycle;
// a request that lands before the epoch (negative offset) skips the date walk and
// reads 1969-12-31; the result sits in an output register, so the next request is
// accepted while an earlier result is still waiting on out_ready
`default_nettype none

module epoch_seconds_to_calendar_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [esc_pkg::OFFSET_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [esc_pkg::EPOCH_W-1:0]   epoch_seconds,
    input  wire logic [esc_pkg::MICRO_W-1:0]   micro_part,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [esc_pkg::YEAR_W-1:0]    cal_year,
    output logic      [esc_pkg::MONTH_W-1:0]   cal_month,
    output logic      [esc_pkg::DAY_W-1:0]     cal_day,
    output logic      [esc_pkg::HOUR_W-1:0]    cal_hour,
    output logic      [esc_pkg::MINUTE_W-1:0]  cal_minute,
    output logic      [esc_pkg::SECOND_W-1:0]  cal_second,
    output logic      [esc_pkg::MICRO_W-1:0]   cal_micro
);

    esc_pkg::esc_cmd_t    cmd;
    esc_pkg::esc_status_t status;

    // offset register always takes a write
    assign cfg_ready = 1'b1;

    // sequencer: walks year, month, day, hour, minute phases
    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // remaining-seconds register, shared subtractor, calendar counters, output register
    esc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .epoch_seconds (epoch_seconds),
        .micro_part    (micro_part),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second),
        .cal_micro     (cal_micro)
    );

endmodule

`default_nettype wire

// ===== rtl/esc_checker.sv =====
`default_nettype none

module esc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [esc_pkg::MONTH_W-1:0]   cal_month,
    input wire logic [esc_pkg::HOUR_W-1:0]    cal_hour,
    input wire logic [esc_pkg::MINUTE_W-1:0]  cal_minute,
    input wire logic [esc_pkg::SECOND_W-1:0]  cal_second,
    input wire logic [esc_pkg::YEAR_W-1:0]    cal_year
);

    // one request in flight: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready held after a request was taken");

    // a result never appears the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result rose too early after a request");

    // month, hour, minute and second fields stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_hour < 5'd24)
                      && (cal_minute < 6'd60) && (cal_second < 6'd60))
        else $error("calendar field out of range");

    // a stalled result stays valid and keeps its year and month
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cal_year)
                                       && $stable(cal_month)))
        else $error("stalled result changed");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cal_month  (cal_month),
    .cal_hour   (cal_hour),
    .cal_minute (cal_minute),
    .cal_second (cal_second),
    .cal_year   (cal_year)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1500000;
    // margin at the end of the run, once no results are outstanding
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_PCT      = 26;
    localparam int RAND_PHASES   = 14;
    localparam int PHASE_REQS    = 100;
    localparam int DAY_SECS      = 86400;
    localparam int HOUR_SECS     = 3600;
    localparam longint EPOCH_MAX = 64'd2147483647;

    // one converted timestamp, fields at the block's widths
    typedef struct packed {
        logic [esc_pkg::YEAR_W-1:0]   year;
        logic [esc_pkg::MONTH_W-1:0]  month;
        logic [esc_pkg::DAY_W-1:0]    day;
        logic [esc_pkg::HOUR_W-1:0]   hour;
        logic [esc_pkg::MINUTE_W-1:0] minute;
        logic [esc_pkg::SECOND_W-1:0] second;
        logic [esc_pkg::MICRO_W-1:0]  micro;
    } cal_t;

    // directed stimulus row: zone to run under, request, and a typed-in answer
    // where it is obvious from the calendar
    typedef struct {
        int                          zone;
        logic [esc_pkg::EPOCH_W-1:0] secs;
        logic [esc_pkg::MICRO_W-1:0] micro;
        bit                          typed;
        cal_t                        want;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [esc_pkg::OFFSET_W-1:0] cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [esc_pkg::EPOCH_W-1:0]  epoch_seconds;
    logic [esc_pkg::MICRO_W-1:0]  micro_part;
    logic                         out_valid;
    logic                         out_ready;
    logic [esc_pkg::YEAR_W-1:0]   cal_year;
    logic [esc_pkg::MONTH_W-1:0]  cal_month;
    logic [esc_pkg::DAY_W-1:0]    cal_day;
    logic [esc_pkg::HOUR_W-1:0]   cal_hour;
    logic [esc_pkg::MINUTE_W-1:0] cal_minute;
    logic [esc_pkg::SECOND_W-1:0] cal_second;
    logic [esc_pkg::MICRO_W-1:0]  cal_micro;

    // dates still owed by the block, oldest first
    cal_t pending_dates[$];
    // local copy of the zone register
    int   cur_zone;
    int   mismatches;
    int   cycles;
    // when set neither side idles
    bit   calm;

    dir_row_t dir_rows [0:21] = '{
        // reset zone of +8 hours
        '{8, 31'd0, 20'd0, 1'b1,
          '{11'd1970, 4'd1, 5'd1, 5'd8, 6'd0, 6'd0, 20'd0}},
        '{8, 31'd2147483647, 20'd999999, 1'b1,
          '{11'd2038, 4'd1, 5'd19, 5'd11, 6'd14, 6'd7, 20'd999999}},
        // micro part above a second is passed through as is
        '{8, 31'd0, 20'hFFFFF, 1'b1,
          '{11'd1970, 4'd1, 5'd1, 5'd8, 6'd0, 6'd0, 20'hFFFFF}},
        '{8, 31'd951782400, 20'h55555, 1'b0, '0},
        '{8, 31'h2AAAAAAA, 20'hAAAAA, 1'b0, '0},
        // utc
        '{0, 31'd0, 20'd0, 1'b1,
          '{11'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
        '{0, 31'd946684799, 20'd123456, 1'b1,
          '{11'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 20'd123456}},
        // end of the leap day in a century leap year
        '{0, 31'd951868799, 20'd0, 1'b0, '0},
        '{0, 31'd1735603200, 20'd7, 1'b0, '0},
        '{0, 31'h55555555, 20'd0, 1'b0, '0},
        // a negative zone pushes early stamps back into 1969
        '{-1, 31'd1, 20'd0, 1'b1,
          '{11'd1969, 4'd12, 5'd31, 5'd23, 6'd0, 6'd1, 20'd0}},
        '{-16, 31'd0, 20'd0, 1'b1,
          '{11'd1969, 4'd12, 5'd31, 5'd8, 6'd0, 6'd0, 20'd0}},
        '{-16, 31'd57599, 20'd999999, 1'b1,
          '{11'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 20'd999999}},
        '{-16, 31'd57600, 20'd0, 1'b1,
          '{11'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
        '{-16, 31'd2147483647, 20'd0, 1'b1,
          '{11'd2038, 4'd1, 5'd18, 5'd11, 6'd14, 6'd7, 20'd0}},
        '{-12, 31'd43199, 20'd1, 1'b0, '0},
        '{-12, 31'd2147483647, 20'd0, 1'b0, '0},
        '{14, 31'd2147483647, 20'd0, 1'b0, '0},
        '{15, 31'd2147483647, 20'hFFFFF, 1'b1,
          '{11'd2038, 4'd1, 5'd19, 5'd18, 6'd14, 6'd7, 20'hFFFFF}},
        '{15, 31'd0, 20'd0, 1'b1,
          '{11'd1970, 4'd1, 5'd1, 5'd15, 6'd0, 6'd0, 20'd0}},
        '{7, 31'h2AAAAAAA, 20'd0, 1'b0, '0},
        // leap day 2024 seen from a zone behind utc
        '{-9, 31'd1709164800, 20'd0, 1'b0, '0}
    };

    epoch_seconds_to_calendar_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .epoch_seconds (epoch_seconds),
        .micro_part    (micro_part),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second),
        .cal_micro     (cal_micro)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // gregorian rule: every fourth year, centuries only when divisible by 400
    function automatic bit is_leap_year(int unsigned yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    // local calendar date of a timestamp under a given zone
    function automatic cal_t local_date(logic [esc_pkg::EPOCH_W-1:0] secs,
                                        logic [esc_pkg::MICRO_W-1:0] micro,
                                        logic signed [esc_pkg::OFFSET_W-1:0] zone);
        longint      t;
        longint      span;
        int unsigned yr;
        int unsigned mon;
        int unsigned dd;
        int unsigned rem;
        int          mlen[12];
        cal_t        d;
        begin
            mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            t = longint'(secs) + longint'(zone) * HOUR_SECS;
            if (t < 0)
            begin
                // at most sixteen hours back, so always the last day of 1969
                yr  = 1969;
                mon = 12;
                dd  = 31;
                t   = t + DAY_SECS;
            end
            else
            begin
                yr = 1970;
                span = (is_leap_year(yr) ? 366 : 365) * longint'(DAY_SECS);
                while (t >= span)
                begin
                    t    = t - span;
                    yr   = yr + 1;
                    span = (is_leap_year(yr) ? 366 : 365) * longint'(DAY_SECS);
                end
                if (is_leap_year(yr))
                    mlen[1] = 29;
                mon = 1;
                while (mon < 12 && t >= longint'(mlen[mon-1]) * DAY_SECS)
                begin
                    t   = t - longint'(mlen[mon-1]) * DAY_SECS;
                    mon = mon + 1;
                end
                dd = int'(t / DAY_SECS) + 1;
                t  = t - longint'(dd - 1) * DAY_SECS;
            end
            rem      = int'(t);
            d.year   = yr[esc_pkg::YEAR_W-1:0];
            d.month  = mon[esc_pkg::MONTH_W-1:0];
            d.day    = dd[esc_pkg::DAY_W-1:0];
            d.hour   = 5'(rem / HOUR_SECS);
            d.minute = 6'((rem % HOUR_SECS) / 60);
            d.second = 6'(rem % 60);
            d.micro  = micro;
            return d;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        begin
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
            mismatches++;
        end
    endtask

    task automatic compare_date(cal_t got, cal_t want);
        begin
            if (got.year !== want.year)
                report_mismatch("year", got.year, want.year);
            if (got.month !== want.month)
                report_mismatch("month", got.month, want.month);
            if (got.day !== want.day)
                report_mismatch("day", got.day, want.day);
            if (got.hour !== want.hour)
                report_mismatch("hour", got.hour, want.hour);
            if (got.minute !== want.minute)
                report_mismatch("minute", got.minute, want.minute);
            if (got.second !== want.second)
                report_mismatch("second", got.second, want.second);
            if (got.micro !== want.micro)
                report_mismatch("micro", got.micro, want.micro);
        end
    endtask

    // change the zone only once the block has handed back everything it owes;
    // called at a clock edge
    task automatic write_zone(int zone);
        begin
            in_valid <= 1'b0;
            while (pending_dates.size() != 0)
                @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= zone[esc_pkg::OFFSET_W-1:0];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            cur_zone = zone;
        end
    endtask

    // present one request, with random idle cycles ahead of it; returns at the
    // edge where it was taken
    task automatic send_request(logic [esc_pkg::EPOCH_W-1:0] secs,
                                logic [esc_pkg::MICRO_W-1:0] micro,
                                cal_t want);
        begin
            while (!calm && $urandom_range(99, 0) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            epoch_seconds <= secs;
            micro_part    <= micro;
            do
                @(posedge clk);
            while (!in_ready);
            pending_dates.push_back(want);
        end
    endtask

    // result side: check what was taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
                report_mismatch("unexpected result, year", cal_year, 0);
            else
                compare_date('{cal_year, cal_month, cal_day, cal_hour, cal_minute,
                               cal_second, cal_micro}, pending_dates.pop_front());
        end
        out_ready <= rst_n && (calm || $urandom_range(99, 0) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_dates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                          zone;
        int                          i;
        int                          ph;
        longint                      pick;
        logic [esc_pkg::EPOCH_W-1:0] secs;
        logic [esc_pkg::MICRO_W-1:0] micro;
        cal_t                        want;

        mismatches    = 0;
        cycles        = 0;
        calm          = 1'b0;
        cur_zone      = int'(esc_pkg::OFFSET_RESET);
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        epoch_seconds = '0;
        micro_part    = '0;
        out_ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, the first ones run on the reset zone
        for (i = 0; i < $size(dir_rows); i++)
        begin
            if (dir_rows[i].zone != cur_zone)
                write_zone(dir_rows[i].zone);
            want = dir_rows[i].typed ? dir_rows[i].want :
                   local_date(dir_rows[i].secs, dir_rows[i].micro,
                              cur_zone[esc_pkg::OFFSET_W-1:0]);
            send_request(dir_rows[i].secs, dir_rows[i].micro, want);
        end

        // random phases, each under its own zone; extremes come first
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       zone = -12;
                1:       zone = 14;
                2:       zone = -16;
                3:       zone = 15;
                4:       zone = 8;
                default: zone = int'($signed(5'($urandom_range(31, 0))));
            endcase
            write_zone(zone);
            // a long stretch without back-pressure or gaps
            calm = (ph == 6) || (ph == 7);
            for (i = 0; i < PHASE_REQS; i++)
            begin
                case ($urandom_range(9, 0))
                    0: pick = $urandom_range(200000, 0);
                    1: pick = EPOCH_MAX - $urandom_range(200000, 0);
                    2, 3, 4:
                    begin
                        // close to a local midnight, where day, month and year roll
                        pick = longint'($urandom_range(24855, 0)) * DAY_SECS
                               - longint'(cur_zone) * HOUR_SECS
                               + $urandom_range(4, 0) - 2;
                    end
                    default: pick = $urandom & 32'h7FFF_FFFF;
                endcase
                if (pick < 0)
                    pick = 0;
                if (pick > EPOCH_MAX)
                    pick = EPOCH_MAX;
                secs = pick[esc_pkg::EPOCH_W-1:0];
                if ($urandom_range(4, 0) == 0)
                    micro = 20'($urandom);
                else
                    micro = 20'($urandom_range(999999, 0));
                send_request(secs, micro,
                             local_date(secs, micro, cur_zone[esc_pkg::OFFSET_W-1:0]));
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/esc_pkg.sv
rtl/esc_datapath.sv
rtl/esc_ctrl.sv
rtl/epoch_seconds_to_calendar_core.sv
rtl/esc_checker.sv
dv/tb_top.sv
